// ----- design/qbd_pkg.sv -----
// Package: shared types, block constants and FP helper functions for the dequantizer.
`timescale 1ns / 1ps
`default_nettype none
package qbd_pkg;

  localparam logic [7:0] Q8_LEN  = 8'd34;
  localparam logic [7:0] Q8_HDR  = 8'd2;
  localparam logic [7:0] Q4K_LEN = 8'd144;
  localparam logic [7:0] Q4K_HDR = 8'd16;

  localparam logic [31:0] FP_QNAN_DEFAULT = 32'hFFC0_0000;
  localparam logic [31:0] FP_QUIET_BIT    = 32'h0040_0000;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_Q8,
    OP_DS,
    OP_MM,
    OP_PR,
    OP_SUB
  } dp_op_t;

  // controller -> datapath
  typedef struct packed {
    logic   take;   // input word accepted this cycle
    dp_op_t op;
    logic   half;   // 0: low nibble, 1: high nibble
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic hdr_hit;  // last accepted byte went to the header
    logic mode;     // 1: Q4_K
  } dp_sts_t;

  // fp16 -> fp32, exact
  function automatic logic [31:0] half_to_float(input logic [15:0] h);
    logic [4:0]  ex;
    logic [9:0]  man;
    logic [10:0] sh;
    logic [7:0]  e;
    logic [31:0] res;
    int          p;
    ex  = h[14:10];
    man = h[9:0];
    p   = 0;
    sh  = '0;
    e   = '0;
    if (ex == 5'd0) begin
      if (man == 10'd0) begin
        res = {h[15], 31'd0};
      end else begin
        for (int i = 0; i < 10; i++) begin
          if (man[i]) p = i;
        end
        sh  = {1'b0, man} << (10 - p);
        e   = 8'(113 - (10 - p));
        res = {h[15], e, sh[9:0], 13'd0};
      end
    end else if (ex == 5'h1f) begin
      res = {h[15], 8'hff, man, 13'd0};
    end else begin
      res = {h[15], 8'({3'd0, ex} + 8'd112), man, 13'd0};
    end
    return res;
  endfunction

  // unsigned 8-bit integer -> fp32 (always exact)
  function automatic logic [31:0] u8_to_float(input logic [7:0] v);
    logic [30:0] tmp;
    logic [31:0] res;
    int          p;
    p   = 0;
    tmp = '0;
    if (v == 8'd0) begin
      res = 32'd0;
    end else begin
      for (int i = 0; i < 8; i++) begin
        if (v[i]) p = i;
      end
      tmp = {23'd0, v} << (23 - p);
      res = {1'b0, 8'(127 + p), tmp[22:0]};
    end
    return res;
  endfunction

  function automatic logic [31:0] s8_to_float(input logic [7:0] b);
    logic [7:0]  mag;
    logic [31:0] f;
    mag = b[7] ? 8'(-b) : b;
    f   = u8_to_float(mag);
    return {b[7] & (mag != 8'd0), f[30:0]};
  endfunction

  // fp32 multiply, round to nearest even; NaN of first operand wins
  function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
    logic        s, a_inf, b_inf, a_zero, b_zero;
    logic [47:0] p;
    logic [9:0]  eb;
    logic [22:0] m;
    logic        g, st, inc;
    logic [32:0] r;
    logic [31:0] res;
    s      = a[31] ^ b[31];
    a_inf  = (a[30:23] == 8'hff) && (a[22:0] == 23'd0);
    b_inf  = (b[30:23] == 8'hff) && (b[22:0] == 23'd0);
    a_zero = (a[30:23] == 8'h00);
    b_zero = (b[30:23] == 8'h00);
    p      = {1'b1, a[22:0]} * {1'b1, b[22:0]};
    eb     = {2'd0, a[30:23]} + {2'd0, b[30:23]} + {9'd0, p[47]};
    if (p[47]) begin
      m = p[46:24]; g = p[23]; st = |p[22:0];
    end else begin
      m = p[45:23]; g = p[22]; st = |p[21:0];
    end
    inc = g & (st | m[0]);
    r   = {10'(eb - 10'd127), m} + 33'(inc);
    if (a[30:23] == 8'hff && a[22:0] != 23'd0) begin
      res = a | FP_QUIET_BIT;
    end else if (b[30:23] == 8'hff && b[22:0] != 23'd0) begin
      res = b | FP_QUIET_BIT;
    end else if ((a_inf && b_zero) || (b_inf && a_zero)) begin
      res = FP_QNAN_DEFAULT;
    end else if (a_inf || b_inf) begin
      res = {s, 8'hff, 23'd0};
    end else if (a_zero || b_zero || eb <= 10'd127) begin
      res = {s, 31'd0};
    end else if (r[32:23] >= 10'd255) begin
      res = {s, 8'hff, 23'd0};
    end else begin
      res = {s, r[30:0]};
    end
    return res;
  endfunction

  // fp32 a - b, round to nearest even; NaN of first operand wins
  function automatic logic [31:0] fp_sub(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] nb, x, y, res;
    logic        a_inf, b_inf, a_zero, b_zero, st;
    logic [7:0]  d;
    logic [26:0] mx, my, sm, sh, df, m;
    logic [27:0] s28;
    logic [9:0]  e;
    logic [32:0] r;
    logic        inc, zero_res;
    int          lz;
    nb     = {~b[31], b[30:0]};
    a_inf  = (a[30:23] == 8'hff) && (a[22:0] == 23'd0);
    b_inf  = (b[30:23] == 8'hff) && (b[22:0] == 23'd0);
    a_zero = (a[30:23] == 8'h00);
    b_zero = (b[30:23] == 8'h00);
    if (a[30:0] < nb[30:0]) begin
      x = nb; y = a;
    end else begin
      x = a; y = nb;
    end
    mx = {1'b1, x[22:0], 3'd0};
    my = {1'b1, y[22:0], 3'd0};
    d  = x[30:23] - y[30:23];
    if (d >= 8'd27) begin
      sm = 27'd1;
    end else begin
      sh = my >> d;
      st = |(my & ((27'd1 << d) - 27'd1));
      sm = {sh[26:1], sh[0] | st};
    end
    zero_res = 1'b0;
    lz       = 0;
    s28      = '0;
    df       = '0;
    if (x[31] == y[31]) begin
      s28 = {1'b0, mx} + {1'b0, sm};
      if (s28[27]) begin
        m = {s28[27:2], s28[1] | s28[0]};
        e = {2'd0, x[30:23]} + 10'd1;
      end else begin
        m = s28[26:0];
        e = {2'd0, x[30:23]};
      end
    end else begin
      df = mx - sm;
      for (int i = 0; i < 27; i++) begin
        if (df[i]) lz = 26 - i;
      end
      zero_res = (df == 27'd0);
      m = df << lz;
      e = {2'd0, x[30:23]} - 10'(lz);
      if ({2'd0, x[30:23]} <= 10'(lz)) zero_res = 1'b1;
    end
    inc = m[2] & (m[1] | m[0] | m[3]);
    r   = {e, m[25:3]} + 33'(inc);
    if (a[30:23] == 8'hff && a[22:0] != 23'd0) begin
      res = a | FP_QUIET_BIT;
    end else if (b[30:23] == 8'hff && b[22:0] != 23'd0) begin
      res = b | FP_QUIET_BIT;
    end else if (a_inf && b_inf && (a[31] != nb[31])) begin
      res = FP_QNAN_DEFAULT;
    end else if (a_inf) begin
      res = a;
    end else if (b_inf) begin
      res = nb;
    end else if (a_zero && b_zero) begin
      res = {a[31] & nb[31], 31'd0};
    end else if (a_zero) begin
      res = nb;
    end else if (b_zero) begin
      res = a;
    end else if (zero_res) begin
      res = 32'd0;
    end else if (r[32:23] >= 10'd255) begin
      res = {x[31], 8'hff, 23'd0};
    end else begin
      res = {x[31], r[30:0]};
    end
    return res;
  endfunction

  // 6-bit scale/min of sub-block j from the 12 packed bytes
  function automatic logic [11:0] scale_min(input logic [95:0] s, input logic [2:0] j);
    logic [7:0] b0, b1, b2;
    logic [5:0] sc, mn;
    b0 = '0; b1 = '0; b2 = '0;
    unique case (j)
      3'd0: begin b0 = s[7:0];   b1 = s[39:32]; end
      3'd1: begin b0 = s[15:8];  b1 = s[47:40]; end
      3'd2: begin b0 = s[23:16]; b1 = s[55:48]; end
      3'd3: begin b0 = s[31:24]; b1 = s[63:56]; end
      3'd4: begin b0 = s[71:64]; b1 = s[7:0];   b2 = s[39:32]; end
      3'd5: begin b0 = s[79:72]; b1 = s[15:8];  b2 = s[47:40]; end
      3'd6: begin b0 = s[87:80]; b1 = s[23:16]; b2 = s[55:48]; end
      3'd7: begin b0 = s[95:88]; b1 = s[31:24]; b2 = s[63:56]; end
      default: begin b0 = '0; end
    endcase
    if (!j[2]) begin
      sc = b0[5:0];
      mn = b1[5:0];
    end else begin
      sc = {b1[7:6], b0[3:0]};
      mn = {b2[7:6], b0[7:4]};
    end
    return {sc, mn};
  endfunction

endpackage
`default_nettype wire

// ----- design/qbd_in_if.sv -----
// Interface: input byte channel.
`timescale 1ns / 1ps
`default_nettype none
interface qbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] block_byte;
  logic       start_of_block;
  modport source (output valid, block_byte, start_of_block, input ready);
  modport sink   (input valid, block_byte, start_of_block, output ready);
endinterface
`default_nettype wire

// ----- design/qbd_out_if.sv -----
// Interface: dequantized value channel.
`timescale 1ns / 1ps
`default_nettype none
interface qbd_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] value_bits;
  logic [7:0]  position;
  logic        last_of_block;
  modport source (output valid, value_bits, position, last_of_block, input ready);
  modport sink   (input valid, value_bits, position, last_of_block, output ready);
endinterface
`default_nettype wire

// ----- design/qbd_cfg_if.sv -----
// Interface: configuration write channel.
`timescale 1ns / 1ps
`default_nettype none
interface qbd_cfg_if;
  logic valid;
  logic ready;
  logic quant_mode;
  modport source (output valid, quant_mode, input ready);
  modport sink   (input valid, quant_mode, output ready);
endinterface
`default_nettype wire

// ----- design/qbd_dp.sv -----
// Datapath: byte counter, header store, shared FP multiplier and subtractor, output word.
`timescale 1ns / 1ps
`default_nettype none
module qbd_dp (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire qbd_pkg::dp_cmd_t cmd,
  output qbd_pkg::dp_sts_t     sts,
  input  wire logic [7:0]      in_byte,
  input  wire logic            in_sob,
  input  wire logic            cfg_we,
  input  wire logic            cfg_mode,
  output logic [31:0]          out_value,
  output logic [7:0]           out_pos,
  output logic                 out_last
);

  logic         mode_r;
  logic [7:0]   cnt_r, cnt_nxt;
  logic [127:0] hdr_r;
  logic [7:0]   byte_r;
  logic [7:0]   c_r;
  logic         hit_r;
  logic [31:0]  t1_r, t2_r;
  logic [31:0]  val_r;
  logic [7:0]   pos_r;
  logic         last_r;

  logic [7:0]   len, hlen, c_eff, c_inc;
  logic [6:0]   k;
  logic [11:0]  scmn;
  logic [31:0]  ma, mb, prod;
  logic [3:0]   nib;

  assign len   = mode_r ? qbd_pkg::Q4K_LEN : qbd_pkg::Q8_LEN;
  assign hlen  = mode_r ? qbd_pkg::Q4K_HDR : qbd_pkg::Q8_HDR;
  assign c_eff = (in_sob || cnt_r >= len) ? 8'd0 : cnt_r;
  assign c_inc = c_eff + 8'd1;
  assign cnt_nxt = (c_inc >= len) ? 8'd0 : c_inc;

  assign k    = 7'(c_r - qbd_pkg::Q4K_HDR);
  assign scmn = qbd_pkg::scale_min(hdr_r[127:32], {k[6:5], cmd.half});
  assign nib  = cmd.half ? byte_r[7:4] : byte_r[3:0];

  // one multiplier, operands picked by the current step
  always_comb begin
    unique case (cmd.op)
      qbd_pkg::OP_Q8: begin
        ma = qbd_pkg::s8_to_float(byte_r);
        mb = qbd_pkg::half_to_float(hdr_r[15:0]);
      end
      qbd_pkg::OP_DS: begin
        ma = qbd_pkg::half_to_float(hdr_r[15:0]);
        mb = qbd_pkg::u8_to_float({2'd0, scmn[11:6]});
      end
      qbd_pkg::OP_MM: begin
        ma = qbd_pkg::half_to_float(hdr_r[31:16]);
        mb = qbd_pkg::u8_to_float({2'd0, scmn[5:0]});
      end
      qbd_pkg::OP_PR: begin
        ma = t1_r;
        mb = qbd_pkg::u8_to_float({4'd0, nib});
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign prod = qbd_pkg::fp_mul(ma, mb);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      cnt_r  <= 8'd0;
      hit_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        mode_r <= cfg_mode;
        cnt_r  <= 8'd0;
      end else if (cmd.take) begin
        cnt_r <= cnt_nxt;
        hit_r <= (c_eff < hlen);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      byte_r <= in_byte;
      c_r    <= c_eff;
      if (c_eff < hlen) begin
        hdr_r[{c_eff[3:0], 3'd0} +: 8] <= in_byte;
      end
    end
    unique case (cmd.op)
      qbd_pkg::OP_Q8: begin
        val_r  <= prod;
        pos_r  <= c_r - qbd_pkg::Q8_HDR;
        last_r <= (c_r == qbd_pkg::Q8_LEN - 8'd1);
      end
      qbd_pkg::OP_DS, qbd_pkg::OP_PR: t1_r <= prod;
      qbd_pkg::OP_MM: t2_r <= prod;
      qbd_pkg::OP_SUB: begin
        val_r  <= qbd_pkg::fp_sub(t1_r, t2_r);
        pos_r  <= {k[6:5], cmd.half, k[4:0]};
        last_r <= cmd.half && (c_r == qbd_pkg::Q4K_LEN - 8'd1);
      end
      default: begin
      end
    endcase
  end

  assign sts.hdr_hit = hit_r;
  assign sts.mode    = mode_r;
  assign out_value   = val_r;
  assign out_pos     = pos_r;
  assign out_last    = last_r;

endmodule
`default_nettype wire

// ----- design/qbd_ctrl.sv -----
// Controller: sequences the multiply/subtract steps and the input/output handshakes.
`timescale 1ns / 1ps
`default_nettype none
module qbd_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  input  wire qbd_pkg::dp_sts_t sts,
  output qbd_pkg::dp_cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_Q8,
    S_DS,
    S_MM,
    S_PR,
    S_SUB,
    S_OUT
  } state_t;

  state_t state_r;
  logic   half_r;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    cmd.take = in_valid && in_ready;
    cmd.half = half_r;
    unique case (state_r)
      S_Q8:    cmd.op = qbd_pkg::OP_Q8;
      S_DS:    cmd.op = qbd_pkg::OP_DS;
      S_MM:    cmd.op = qbd_pkg::OP_MM;
      S_PR:    cmd.op = qbd_pkg::OP_PR;
      S_SUB:   cmd.op = qbd_pkg::OP_SUB;
      default: cmd.op = qbd_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      half_r  <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE:   if (in_valid) state_r <= S_DECIDE;
        S_DECIDE: begin
          half_r <= 1'b0;
          if (sts.hdr_hit)   state_r <= S_IDLE;
          else if (sts.mode) state_r <= S_DS;
          else               state_r <= S_Q8;
        end
        S_Q8:  state_r <= S_OUT;
        S_DS:  state_r <= S_MM;
        S_MM:  state_r <= S_PR;
        S_PR:  state_r <= S_SUB;
        S_SUB: state_r <= S_OUT;
        S_OUT: begin
          if (out_ready) begin
            if (sts.mode && !half_r) begin
              half_r  <= 1'b1;
              state_r <= S_DS;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("input and output open together");
  a_take_decide: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_DECIDE)) else $error("accept not followed by decode");
  a_half_q4: assert property (@(posedge clk) disable iff (!rst_n)
    (half_r && state_r != S_IDLE && state_r != S_DECIDE) |-> sts.mode)
    else $error("high nibble step outside Q4_K");
  a_sub_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SUB) |=> out_valid) else $error("result not presented");

endmodule
`default_nettype wire

// ----- design/quant_block_dequantizer.sv -----
// Top level: Q8_0 / Q4_K block dequantizer.
`timescale 1ns / 1ps
`default_nettype none
// Takes one byte word of a packed quantized block per handshake and returns
// FP32 words with their position in the block. quant_mode selects the format
// (0: Q8_0, 34-byte blocks; 1: Q4_K, 144-byte blocks); a write to it also
// restarts the block. The user must write it only while the block is idle;
// the block does not enforce this. start_of_block forces a byte to be byte 0.
// Header bytes produce no output. A header byte occupies the block for its
// accept and decode states. A Q8_0 quant needs one FP multiply plus output
// wait. A Q4_K nibble byte yields two words, each through four steps on one
// shared FP multiplier and one FP subtractor: d*sc, dmin*m, (d*sc)*q, then
// the subtract, plus output waits. One byte is in flight at a time; the next
// byte is taken once the last word of the current one has been handed off.
// All FP32 arithmetic rounds to nearest even, each step separately.
module quant_block_dequantizer (
  input  wire logic  clk,
  input  wire logic  rst_n,
  qbd_in_if.sink     in_ch,
  qbd_out_if.source  out_ch,
  qbd_cfg_if.sink    cfg_ch
);

  qbd_pkg::dp_cmd_t cmd;
  qbd_pkg::dp_sts_t sts;
  logic             in_ready;

  // config is always taken; the user writes only when idle
  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = in_ready;

  qbd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  qbd_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_byte   (in_ch.block_byte),
    .in_sob    (in_ch.start_of_block),
    .cfg_we    (cfg_ch.valid),
    .cfg_mode  (cfg_ch.quant_mode),
    .out_value (out_ch.value_bits),
    .out_pos   (out_ch.position),
    .out_last  (out_ch.last_of_block)
  );

endmodule
`default_nettype wire
